FILE: rtl/core/idp_pkg.sv
// ----------------------------------------------------------------------------
// idp_pkg
// Shared types, constants and keyword tables for the inline declaration parser.
// ----------------------------------------------------------------------------
package idp_pkg;

   localparam int MaxWords        = 7;
   localparam int MaxStringLength = 256;
   localparam int MaxArraySize    = 65535;
   localparam int NumKw           = 13;
   localparam int NumClass        = 4;
   localparam int PosW            = $clog2(MaxStringLength + 1);

   typedef enum logic [2:0] {
      StOk        = 3'd0,
      StSingle    = 3'd1,
      StEmpty     = 3'd2,
      StSyntax    = 3'd3,
      StForbidden = 3'd4,
      StTooLong   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      PhLead   = 2'd0,
      PhSign   = 2'd1,
      PhDigits = 2'd2,
      PhStop   = 2'd3
   } num_phase_type;

   typedef struct packed {
      logic       has_char;
      logic [7:0] char_code;
      logic       last;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  storage_class;
      logic [3:0]  value_type;
      logic [15:0] array_size;
      logic [7:0]  ident_start;
      logic [8:0]  ident_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  start;
      logic [8:0]  len;
      logic        cls_ok;
      logic [1:0]  cls;
      logic        typ_ok;
      logic [3:0]  typ;
      logic        lb;
      logic        rb;
      logic        num_ok;
      logic [15:0] num;
   } slot_type;

   typedef slot_type [MaxWords-1:0] slots_type;

   typedef struct packed {
      logic       forbidden;
      logic       too_long;
      logic [2:0] words;
   } scan_stat_type;

   // keyword text, lower case, first character in the top byte, zero padded
   localparam logic [NumKw-1:0][63:0] KwText = {
      {"integer", 8'h00},
      {"hpoint", 16'h0000},
      {"matrix", 16'h0000},
      {"string", 16'h0000},
      {"color", 24'h000000},
      {"normal", 16'h0000},
      {"vector", 16'h0000},
      {"point", 24'h000000},
      {"float", 24'h000000},
      {"vertex", 16'h0000},
      {"varying", 8'h00},
      {"uniform", 8'h00},
      "constant"
   };

   localparam logic [NumKw-1:0][3:0] KwLen = {
      4'd7, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd5, 4'd5, 4'd6, 4'd7, 4'd7, 4'd8
   };

endpackage

FILE: rtl/core/idp_scan.sv
// ----------------------------------------------------------------------------
// idp_scan
// Per-character word splitter, keyword matcher and size scanner with the
// seven word slots; presents the slot view including this cycle's commits.
// ----------------------------------------------------------------------------
module idp_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  idp_pkg::req_type       item,
   output idp_pkg::slots_type     slots_view,
   output idp_pkg::scan_stat_type stat_view
);
   import idp_pkg::*;

   logic [PosW-1:0]   pos_ff, pos_in;
   logic              inside_ff, inside_in;
   logic [2:0]        words_ff, words_in;
   logic [NumKw-1:0]  cand_ff, cand_in;
   logic [15:0]       acc_ff, acc_in;
   num_phase_type     phase_ff, phase_in;
   logic              neg_ff, neg_in;
   logic              digit_ff, digit_in;
   logic [7:0]        start_ff, start_in;
   logic [8:0]        len_ff, len_in;
   logic              forb_ff, forb_in;
   logic              long_ff, long_in;
   slots_type         slots_ff;

   function automatic slot_type make_slot(
      input logic [7:0] st, input logic [8:0] ln, input logic [NumKw-1:0] cd,
      input logic [15:0] ac, input logic ng, input logic dg);
      slot_type s;
      s        = '0;
      s.start  = st;
      s.len    = ln;
      for (int k = 0; k < NumKw; k++) begin
         if (cd[k] && (ln == {5'd0, KwLen[k]})) begin
            if (k < NumClass) begin
               s.cls_ok = 1'b1;
               s.cls    = 2'(k);
            end else begin
               s.typ_ok = 1'b1;
               s.typ    = 4'(k - NumClass);
            end
         end
      end
      s.num_ok = dg && !ng && (ac != 16'd0);
      s.num    = ac;
      return s;
   endfunction

   always_comb begin
      logic [7:0]  c;
      logic [7:0]  lc;
      logic [3:0]  d;
      logic        dig;
      logic [19:0] prod;
      slot_type    br;
      pos_in    = pos_ff;
      inside_in = inside_ff;
      words_in  = words_ff;
      cand_in   = cand_ff;
      acc_in    = acc_ff;
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      digit_in  = digit_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      forb_in   = forb_ff;
      long_in   = long_ff;
      slots_view = slots_ff;
      c   = item.char_code;
      lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      d   = 4'(c - "0");
      dig = (c >= "0") && (c <= "9");
      br  = '0;
      prod = '0;
      if (step && item.has_char) begin
         if (pos_ff >= PosW'(MaxStringLength)) begin
            long_in = 1'b1;
         end else begin
            if (!forb_ff && words_ff < 3'(MaxWords)) begin
               if (c == " " || c == 8'h09 || c == 8'h0a) begin
                  if (inside_ff) begin
                     slots_view[words_in] = make_slot(start_in, len_in, cand_in, acc_in,
                                                      neg_in, digit_in);
                     words_in  = words_in + 3'd1;
                     inside_in = 1'b0;
                  end
               end else if (c == "#" || c == 8'h22) begin
                  forb_in = 1'b1;
               end else if (c == "[" || c == "]") begin
                  if (inside_ff) begin
                     slots_view[words_in] = make_slot(start_in, len_in, cand_in, acc_in,
                                                      neg_in, digit_in);
                     words_in  = words_in + 3'd1;
                     inside_in = 1'b0;
                  end
                  if (words_in < 3'(MaxWords)) begin
                     br.start = pos_ff[7:0];
                     br.len   = 9'd1;
                     br.lb    = (c == "[");
                     br.rb    = (c == "]");
                     slots_view[words_in] = br;
                     words_in = words_in + 3'd1;
                  end
               end else begin
                  if (!inside_ff) begin
                     start_in  = pos_ff[7:0];
                     len_in    = 9'd0;
                     cand_in   = '1;
                     acc_in    = '0;
                     phase_in  = PhLead;
                     neg_in    = 1'b0;
                     digit_in  = 1'b0;
                     inside_in = 1'b1;
                  end
                  for (int k = 0; k < NumKw; k++) begin
                     if (cand_in[k] && !((len_in < {5'd0, KwLen[k]}) &&
                         (lc == KwText[k][8*(7-int'(len_in[2:0])) +: 8])))
                        cand_in[k] = 1'b0;
                  end
                  case (phase_in)
                     PhLead: begin
                        if (c == 8'h0b || c == 8'h0c || c == 8'h0d) begin
                           phase_in = PhLead;
                        end else if (c == "+" || c == "-") begin
                           neg_in   = (c == "-");
                           phase_in = PhSign;
                        end else if (dig) begin
                           acc_in   = {12'd0, d};
                           digit_in = 1'b1;
                           phase_in = PhDigits;
                        end else begin
                           phase_in = PhStop;
                        end
                     end
                     PhSign: begin
                        if (dig) begin
                           acc_in   = {12'd0, d};
                           digit_in = 1'b1;
                           phase_in = PhDigits;
                        end else begin
                           phase_in = PhStop;
                        end
                     end
                     PhDigits: begin
                        if (dig) begin
                           prod = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
                                + {16'd0, d};
                           acc_in = (prod > 20'(MaxArraySize)) ? 16'(MaxArraySize)
                                                                : prod[15:0];
                        end else begin
                           phase_in = PhStop;
                        end
                     end
                     default: phase_in = PhStop;
                  endcase
                  len_in = len_in + 9'd1;
               end
            end
            pos_in = pos_ff + PosW'(1);
         end
      end
      if (step && item.last) begin
         if (!forb_in && inside_in && words_in < 3'(MaxWords)) begin
            slots_view[words_in] = make_slot(start_in, len_in, cand_in, acc_in,
                                             neg_in, digit_in);
            words_in = words_in + 3'd1;
         end
      end
      stat_view.forbidden = forb_in;
      stat_view.too_long  = long_in;
      stat_view.words     = words_in;
      if (step && item.last) begin
         pos_in    = '0;
         inside_in = 1'b0;
         words_in  = '0;
         cand_in   = '1;
         acc_in    = '0;
         phase_in  = PhLead;
         neg_in    = 1'b0;
         digit_in  = 1'b0;
         forb_in   = 1'b0;
         long_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         inside_ff <= 1'b0;
         words_ff  <= '0;
         cand_ff   <= '1;
         acc_ff    <= '0;
         phase_ff  <= PhLead;
         neg_ff    <= 1'b0;
         digit_ff  <= 1'b0;
         forb_ff   <= 1'b0;
         long_ff   <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         inside_ff <= inside_in;
         words_ff  <= words_in;
         cand_ff   <= cand_in;
         acc_ff    <= acc_in;
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         digit_ff  <= digit_in;
         forb_ff   <= forb_in;
         long_ff   <= long_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
      if (step) begin
         slots_ff <= slots_view;
      end
   end

endmodule

FILE: rtl/core/idp_verdict.sv
// ----------------------------------------------------------------------------
// idp_verdict
// Shape check over the word slots; forms the result transaction.
// ----------------------------------------------------------------------------
module idp_verdict (
   input  idp_pkg::slots_type     slots,
   input  idp_pkg::scan_stat_type stat,
   output idp_pkg::rsp_type       rsp
);
   import idp_pkg::*;

   always_comb begin
      logic       ok;
      logic [2:0] id;
      ok  = 1'b0;
      id  = 3'd0;
      rsp = '0;
      rsp.status = StSyntax;
      case (stat.words)
         3'd2: begin
            if (slots[0].typ_ok) begin
               ok = 1'b1; id = 3'd1;
               rsp.storage_class = 2'd1;
               rsp.value_type    = slots[0].typ;
               rsp.array_size    = 16'd1;
            end
         end
         3'd3: begin
            if (slots[0].cls_ok && slots[1].typ_ok) begin
               ok = 1'b1; id = 3'd2;
               rsp.storage_class = slots[0].cls;
               rsp.value_type    = slots[1].typ;
               rsp.array_size    = 16'd1;
            end
         end
         3'd5: begin
            if (slots[0].typ_ok && slots[1].lb && slots[2].num_ok && slots[3].rb) begin
               ok = 1'b1; id = 3'd4;
               rsp.storage_class = 2'd1;
               rsp.value_type    = slots[0].typ;
               rsp.array_size    = slots[2].num;
            end
         end
         3'd6: begin
            if (slots[0].cls_ok && slots[1].typ_ok && slots[2].lb && slots[3].num_ok &&
                slots[4].rb) begin
               ok = 1'b1; id = 3'd5;
               rsp.storage_class = slots[0].cls;
               rsp.value_type    = slots[1].typ;
               rsp.array_size    = slots[3].num;
            end
         end
         default: ok = 1'b0;
      endcase
      // error flags take precedence over any shape
      if (stat.forbidden || stat.too_long) ok = 1'b0;
      if (ok) begin
         rsp.status       = StOk;
         rsp.ident_start  = slots[id].start;
         rsp.ident_length = slots[id].len;
      end else begin
         rsp = '0;
         if (stat.forbidden)            rsp.status = StForbidden;
         else if (stat.too_long)        rsp.status = StTooLong;
         else if (stat.words == 3'd0)   rsp.status = StEmpty;
         else if (stat.words == 3'd1)   rsp.status = StSingle;
         else                           rsp.status = StSyntax;
      end
   end

endmodule

FILE: rtl/core/inline_declaration_parser.sv
// ----------------------------------------------------------------------------
// inline_declaration_parser
// The input register takes the final character's transaction; the verdict is
// written to the result register when it advances. Throughput: one character
// per cycle, back to back; the input stalls only while a finished verdict
// waits on a stalled receiver.
// Reset: synchronous; clears the parser state and the valid flags.
// ----------------------------------------------------------------------------
module inline_declaration_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  idp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output idp_pkg::rsp_type rsp_data
);
   import idp_pkg::*;

   logic          in_valid_ff, in_valid_in;
   req_type       in_data_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff;
   logic          advance;
   logic          accept;
   slots_type     slots_view;
   scan_stat_type stat_view;
   rsp_type       verdict;

   assign advance   = in_valid_ff && !(in_data_ff.last && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   idp_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_data_ff),
      .slots_view (slots_view),
      .stat_view  (stat_view)
   );

   idp_verdict u_verdict (
      .slots (slots_view),
      .stat  (stat_view),
      .rsp   (verdict)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept)       in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (advance && in_data_ff.last) out_valid_in = 1'b1;
      else if (!rsp_stall)            out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance && in_data_ff.last) begin
         out_data_ff <= verdict;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(in_valid_ff && in_data_ff.last))
      else $error("result without a final character");

   a_ok_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == StOk) |-> (rsp_data.array_size != 16'd0))
      else $error("ok verdict with zero size");

   a_err_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != StOk) |->
      (rsp_data.storage_class == 2'd0 && rsp_data.value_type == 4'd0 &&
       rsp_data.array_size == 16'd0 && rsp_data.ident_length == 9'd0))
      else $error("error verdict with non-zero fields");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_data_ff.last && out_valid_ff))
      else $error("input stalled without a blocked verdict");

endmodule
